// File: rtl/core/dtrmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrmc_pkg
// Types, codes and helpers shared by the dial-to-relative controller block.
// ----------------------------------------------------------------------------
package dtrmc_pkg;

    localparam int unsigned VAL_W    = 16;
    localparam int unsigned LIM_W    = 6;
    localparam int unsigned CC_W     = 7;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 7;
    localparam int unsigned CNT_W    = 6;   // chunk counter, at most 64 chunks per run

    localparam logic [7:0]      HDR_FIRST      = 8'h30;
    localparam logic [CC_W-1:0] BASE_RESET     = 7'd20;
    localparam logic [LIM_W-1:0] LIMIT_RESET   = 6'd63;
    localparam logic [CNT_W-1:0] CNT_LAST      = 6'd63;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CONTROLLER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT      = 8'd1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SAT,
        ST_EMIT,
        ST_HOLD
    } t_state;

    // a zero limit behaves as one
    function automatic logic [LIM_W-1:0] f_eff_limit(input logic [LIM_W-1:0] lim);
        f_eff_limit = (lim == '0) ? LIM_W'(1) : lim;
    endfunction

endpackage

// File: rtl/core/dtrmc_chunk_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrmc_chunk_unit
// Clamp/subtract unit: cuts one chunk of at most the step limit off the
// signed remainder. Used once per emitted message.
// ----------------------------------------------------------------------------
module dtrmc_chunk_unit (
    input  logic [dtrmc_pkg::VAL_W-1:0] i_rem,
    input  logic [dtrmc_pkg::LIM_W-1:0] i_lim,
    output logic [dtrmc_pkg::VAL_W-1:0] o_chunk,
    output logic [dtrmc_pkg::VAL_W-1:0] o_rem_next
);

    logic [dtrmc_pkg::VAL_W-1:0] lim_pos;
    logic [dtrmc_pkg::VAL_W-1:0] lim_neg;

    assign lim_pos = {{(dtrmc_pkg::VAL_W - dtrmc_pkg::LIM_W){1'b0}},
                      dtrmc_pkg::f_eff_limit(i_lim)};
    assign lim_neg = dtrmc_pkg::VAL_W'(0) - lim_pos;

    always_comb begin
        if (!i_rem[dtrmc_pkg::VAL_W-1]) begin
            o_chunk = (i_rem > lim_pos) ? lim_pos : i_rem;
        end else begin
            o_chunk = ($signed(i_rem) < $signed(lim_neg)) ? lim_neg : i_rem;
        end
    end

    assign o_rem_next = i_rem - o_chunk;

endmodule

// File: rtl/core/dial_to_relative_midi_cc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dial_to_relative_midi_cc
// Parses dial position packets from a byte stream and emits relative
// controller messages for the change of each dial.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one received byte per beat. A header 0x30.. selects a dial, then the
//         high and low bytes of its new 16-bit position follow. Other bytes in
//         the header phase are dropped.
//   m_* : one controller message per beat; tdata = {cc_value, cc_number},
//         tuser = saturated, tlast marks the final chunk of a run.
//   cfg : register writes (0 base controller, 1 step limit), always ready.
// Sequence:
//   Header and high bytes are taken while idle. After a low byte the
//   difference and the saturation check are registered in turn, then each
//   chunk passes the shared clamp/subtract unit and the output register,
//   where it waits while the sink holds m_tready low. A run has at most 64
//   chunks. s_tready is low for the whole run.
// Reset: synchronous, active low; parser waits for a header, all stored dial
//   positions read zero, registers return to 20 and 63.
// Stall: a pending message holds until taken; the run does not advance.
// ----------------------------------------------------------------------------
module dial_to_relative_midi_cc #(
    parameter int unsigned DIAL_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream: [7:0] rx_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // output stream: [6:0] cc_number, [13:7] cc_value, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // [0] saturated
    output logic        m_tuser,
    output logic        m_tlast,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dtrmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dtrmc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = (DIAL_COUNT > 1) ? $clog2(DIAL_COUNT) : 1;
    localparam logic [7:0]  HDR_LAST = 8'(32'(dtrmc_pkg::HDR_FIRST) + DIAL_COUNT - 1);
    localparam int unsigned VW = dtrmc_pkg::VAL_W;
    localparam int unsigned CW = dtrmc_pkg::CC_W;

    dtrmc_pkg::t_state r_state, n_state;
    dtrmc_pkg::t_phase r_phase;

    logic [CW-1:0]                 r_base;
    logic [dtrmc_pkg::LIM_W-1:0]   r_limit;
    logic [IDX_W-1:0]              r_dial;
    logic [7:0]                    r_high;
    logic [VW-1:0]                 r_newval;
    logic [VW-1:0]                 r_vals [DIAL_COUNT];
    logic [VW-1:0]                 r_rem;
    logic                          r_sat;
    logic [dtrmc_pkg::CNT_W-1:0]   r_cnt;
    logic                          r_out_valid;
    logic [CW-1:0]                 r_out_num;
    logic [CW-1:0]                 r_out_val;
    logic                          r_out_sat;
    logic                          r_out_last;

    logic           in_beat;
    logic           out_beat;
    logic           is_header;
    logic [VW-1:0]  chunk;
    logic [VW-1:0]  rem_next;
    logic [VW-1:0]  mag;
    logic [VW-1:0]  sat_bound;
    logic [CW-1:0]  cc_num;

    assign in_beat   = s_tvalid && s_tready;
    assign out_beat  = r_out_valid && m_tready;
    assign is_header = (s_tdata >= dtrmc_pkg::HDR_FIRST) && (s_tdata <= HDR_LAST);
    assign mag       = r_rem[VW-1] ? (VW'(0) - r_rem) : r_rem;
    // more than 64 chunks needed exactly when |d| > 64 * limit
    assign sat_bound = {{(VW - dtrmc_pkg::LIM_W - 6){1'b0}},
                        dtrmc_pkg::f_eff_limit(r_limit), 6'b0};
    assign cc_num    = r_base + CW'(r_dial);

    dtrmc_chunk_unit u_chunk (
        .i_rem      (r_rem),
        .i_lim      (r_limit),
        .o_chunk    (chunk),
        .o_rem_next (rem_next)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtrmc_pkg::ST_IDLE: begin
                if (in_beat && r_phase == dtrmc_pkg::PH_LOW) n_state = dtrmc_pkg::ST_DIFF;
            end
            dtrmc_pkg::ST_DIFF: n_state = dtrmc_pkg::ST_SAT;
            dtrmc_pkg::ST_SAT: begin
                n_state = (r_rem == '0) ? dtrmc_pkg::ST_IDLE : dtrmc_pkg::ST_EMIT;
            end
            dtrmc_pkg::ST_EMIT: n_state = dtrmc_pkg::ST_HOLD;
            dtrmc_pkg::ST_HOLD: begin
                if (out_beat) n_state = r_out_last ? dtrmc_pkg::ST_IDLE : dtrmc_pkg::ST_EMIT;
            end
            default: n_state = dtrmc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (r_state == dtrmc_pkg::ST_IDLE);
    end

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_out_valid;
    assign m_tdata     = {2'b00, r_out_val, r_out_num};
    assign m_tuser     = r_out_sat;
    assign m_tlast     = r_out_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtrmc_pkg::ST_IDLE;
            r_phase     <= dtrmc_pkg::PH_HEADER;
            r_dial      <= '0;
            r_high      <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
            r_base      <= dtrmc_pkg::BASE_RESET;
            r_limit     <= dtrmc_pkg::LIMIT_RESET;
            for (int i = 0; i < DIAL_COUNT; i++) r_vals[i] <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    dtrmc_pkg::CFG_BASE_CONTROLLER: r_base  <= i_cfg_data;
                    dtrmc_pkg::CFG_STEP_LIMIT:      r_limit <= i_cfg_data[dtrmc_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end

            if (in_beat) begin
                case (r_phase)
                    dtrmc_pkg::PH_HIGH: begin
                        r_high  <= s_tdata;
                        r_phase <= dtrmc_pkg::PH_LOW;
                    end
                    dtrmc_pkg::PH_LOW: r_phase <= dtrmc_pkg::PH_HEADER;
                    default: begin
                        if (is_header) begin
                            r_dial  <= IDX_W'(s_tdata - dtrmc_pkg::HDR_FIRST);
                            r_phase <= dtrmc_pkg::PH_HIGH;
                        end else begin
                            r_phase <= dtrmc_pkg::PH_HEADER;
                        end
                    end
                endcase
            end

            case (r_state)
                dtrmc_pkg::ST_DIFF: begin
                    r_rem          <= r_newval - r_vals[r_dial];
                    r_vals[r_dial] <= r_newval;
                end
                dtrmc_pkg::ST_EMIT: begin
                    r_rem       <= rem_next;
                    r_out_valid <= 1'b1;
                end
                dtrmc_pkg::ST_HOLD: begin
                    if (out_beat) r_out_valid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_beat && r_phase == dtrmc_pkg::PH_LOW) r_newval <= {r_high, s_tdata};
        case (r_state)
            dtrmc_pkg::ST_SAT: begin
                r_sat <= (mag > sat_bound);
                r_cnt <= '0;
            end
            dtrmc_pkg::ST_EMIT: begin
                r_out_num  <= cc_num;
                r_out_val  <= chunk[CW-1:0];
                r_out_sat  <= r_sat;
                r_out_last <= (rem_next == '0) || (r_cnt == dtrmc_pkg::CNT_LAST);
                r_cnt      <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/dtrmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrmc_checker
// Port-level checks for the dial-to-relative controller block.
// ----------------------------------------------------------------------------
module dtrmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // no new byte is taken while a message is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready during output run");

    // every chunk moves the dial
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[13:7] != 7'd0) && (m_tdata[15:14] == 2'b00))
        else $error("zero chunk or nonzero pad");

    // after the final chunk the block returns to taking bytes
    a_end_of_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("run did not end after last beat");

endmodule

bind dial_to_relative_midi_cc dtrmc_checker u_dtrmc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: bench/dial_delta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dial_delta_checker
// Watches the byte, message and register channels of the dial translator.
// It tracks the parser, the stored dial positions and the register values,
// expands each completed position packet into its run of controller
// messages, and compares every message beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module dial_delta_checker #(
    parameter int unsigned DIAL_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [dtrmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dtrmc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_msg_count,
    output int          o_run_count,
    output int          o_sat_runs
);

    localparam int MAX_CHUNKS = 64;

    typedef struct packed {
        logic [dtrmc_pkg::CC_W-1:0] cc_number;
        logic [6:0]                 cc_value;
        logic                       saturated;
        logic                       last;
    } t_cc_msg;

    t_cc_msg                       pending_chunks [$];

    dtrmc_pkg::t_phase             phase;
    logic [2:0]                    dial_sel;
    logic [7:0]                    hi_byte;
    logic [dtrmc_pkg::VAL_W-1:0]   dial_pos [8];
    logic [dtrmc_pkg::CC_W-1:0]    base_cc;
    logic [dtrmc_pkg::LIM_W-1:0]   chunk_limit;

    always @(posedge i_clk) begin : monitor
        t_cc_msg                     want;
        logic [dtrmc_pkg::VAL_W-1:0] new_pos;
        logic [dtrmc_pkg::VAL_W-1:0] delta;
        logic [dtrmc_pkg::CC_W-1:0]  ccn;
        logic                        sat;
        int                          d;
        int                          lim;
        int                          mag;
        int                          v;
        int                          n;

        if (!i_rst_n) begin
            phase       = dtrmc_pkg::PH_HEADER;
            dial_sel    = '0;
            hi_byte     = '0;
            dial_pos    = '{default: '0};
            base_cc     = dtrmc_pkg::BASE_RESET;
            chunk_limit = dtrmc_pkg::LIMIT_RESET;
            pending_chunks.delete();
        end else begin
            // message beats first: a byte taken on this edge cannot feed them
            if (i_m_tvalid && i_m_tready) begin
                o_msg_count++;
                if (pending_chunks.size() == 0) begin
                    $error("unexpected message: cc_number %0d cc_value %0d",
                           i_m_tdata[6:0], i_m_tdata[13:7]);
                    o_fail_count++;
                end else begin
                    want = pending_chunks.pop_front();
                    if (i_m_tdata[6:0] !== want.cc_number) begin
                        $error("cc_number: expected %0d, got %0d",
                               want.cc_number, i_m_tdata[6:0]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[13:7] !== want.cc_value) begin
                        $error("cc_value: expected %0d, got %0d",
                               want.cc_value, i_m_tdata[13:7]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[15:14] !== 2'b00) begin
                        $error("tdata pad: expected 0, got %0d", i_m_tdata[15:14]);
                        o_fail_count++;
                    end
                    if (i_m_tuser !== want.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               want.saturated, i_m_tuser);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    dtrmc_pkg::CFG_BASE_CONTROLLER: base_cc = i_cfg_data;
                    dtrmc_pkg::CFG_STEP_LIMIT:
                        chunk_limit = i_cfg_data[dtrmc_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                case (phase)
                    dtrmc_pkg::PH_HIGH: begin
                        hi_byte = i_s_tdata;
                        phase   = dtrmc_pkg::PH_LOW;
                    end
                    dtrmc_pkg::PH_LOW: begin
                        phase   = dtrmc_pkg::PH_HEADER;
                        new_pos = {hi_byte, i_s_tdata};
                        delta   = new_pos - dial_pos[dial_sel];
                        d       = int'($signed(delta));
                        dial_pos[dial_sel] = new_pos;
                        lim = (chunk_limit == '0) ? 1 : int'(chunk_limit);
                        mag = (d < 0) ? -d : d;
                        sat = ((mag + lim - 1) / lim) > MAX_CHUNKS;
                        ccn = dtrmc_pkg::CC_W'(base_cc + dial_sel);
                        if (d != 0) begin
                            o_run_count++;
                            if (sat)
                                o_sat_runs++;
                        end
                        n = 0;
                        while (d != 0 && n < MAX_CHUNKS) begin
                            if (d > lim)
                                v = lim;
                            else if (d < -lim)
                                v = -lim;
                            else
                                v = d;
                            d = d - v;
                            want.cc_number = ccn;
                            want.cc_value  = v[6:0];
                            want.saturated = sat;
                            want.last      = (d == 0) || (n == MAX_CHUNKS - 1);
                            pending_chunks.push_back(want);
                            n++;
                        end
                    end
                    default: begin
                        phase = dtrmc_pkg::PH_HEADER;
                        if (i_s_tdata >= dtrmc_pkg::HDR_FIRST &&
                            i_s_tdata < dtrmc_pkg::HDR_FIRST + DIAL_COUNT) begin
                            dial_sel = 3'(i_s_tdata - dtrmc_pkg::HDR_FIRST);
                            phase    = dtrmc_pkg::PH_HIGH;
                        end
                    end
                endcase
            end
        end
        o_pending = pending_chunks.size();
    end

endmodule

// File: bench/dial_to_relative_midi_cc_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dial_to_relative_midi_cc_test
// Drives position packets, stray bytes and register writes into the dial
// translator under several idle and stall mixes, including a long sink
// hold-off, and takes its verdict from the message checker beside the block.
// ----------------------------------------------------------------------------
module dial_to_relative_midi_cc_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [dtrmc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [dtrmc_pkg::CFG_DAT_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int msg_count;
    int run_count;
    int sat_runs;

    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    int   bytes_sent    = 0;
    int   idle_cycles   = 0;
    int   hold_left     = 0;
    int   hold_reqs     = 0;
    int   hold_seen     = 0;
    logic [15:0] sent_pos [8] = '{default: 16'h0};

    dial_to_relative_midi_cc #(
        .DIAL_COUNT(8)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    dial_delta_checker #(
        .DIAL_COUNT(8)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_msg_count (msg_count),
        .o_run_count (run_count),
        .o_sat_runs  (sat_runs)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // sink: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("dial_to_relative_midi_cc: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_position(input logic [2:0] dial, input logic [15:0] pos);
        send_byte(dtrmc_pkg::HDR_FIRST + 8'(dial));
        send_byte(pos[15:8]);
        send_byte(pos[7:0]);
        sent_pos[dial] = pos;
    endtask

    // a zero-difference packet leaves the block busy with nothing due
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [6:0] base, input logic [6:0] limit,
                              input logic [7:0] stray_idx);
        logic [dtrmc_pkg::CFG_IDX_W-1:0] idx [3];
        logic [dtrmc_pkg::CFG_DAT_W-1:0] val [3];
        idx[0] = dtrmc_pkg::CFG_BASE_CONTROLLER;
        val[0] = base;
        idx[1] = dtrmc_pkg::CFG_STEP_LIMIT;
        val[1] = limit;
        idx[2] = stray_idx;
        val[2] = 7'($urandom);
        wait_drained();
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int src_pct, input int snk_pct,
                                    input logic [6:0] base, input logic [6:0] limit,
                                    input logic long_hold, input int nbytes);
        int          sent;
        int          pick;
        logic [2:0]  dial;
        logic [15:0] pos;
        logic [7:0]  noise;
        set_config(base, limit, 8'($urandom_range(2, 255)));
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (long_hold)
            hold_reqs++;
        sent = 0;
        while (sent < nbytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                dial = 3'($urandom_range(0, 7));
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    pos = sent_pos[dial];
                else if (pick < 50)
                    pos = sent_pos[dial] + 16'($urandom_range(0, 80)) - 16'd40;
                else if (pick < 70)
                    pos = sent_pos[dial] + 16'($urandom_range(0, 4000)) - 16'd2000;
                else
                    pos = 16'($urandom);
                send_position(dial, pos);
                sent += 3;
            end else if (pick < 92) begin
                // stray byte outside the header range
                noise = 8'($urandom);
                if (noise >= dtrmc_pkg::HDR_FIRST && noise < dtrmc_pkg::HDR_FIRST + 8)
                    noise ^= 8'h80;
                send_byte(noise);
                sent++;
            end else begin
                // lone header: shifts the packet that follows
                send_byte(dtrmc_pkg::HDR_FIRST + 8'($urandom_range(0, 7)));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset register values
        send_byte(dtrmc_pkg::HDR_FIRST - 8'd1);
        send_byte(dtrmc_pkg::HDR_FIRST + 8'd8);
        send_position(3'd0, 16'h0001);
        send_position(3'd7, 16'h0000);
        send_position(3'd7, 16'hFFFF);
        send_position(3'd1, 16'h7FFF);
        send_position(3'd2, 16'h8000);
        send_position(3'd4, 16'd4032);   // exactly 64 full chunks
        send_position(3'd5, 16'd4033);   // one past: clipped
        // a header, then header-range bytes used as position data
        send_byte(dtrmc_pkg::HDR_FIRST + 8'd3);
        send_byte(dtrmc_pkg::HDR_FIRST + 8'd5);
        send_byte(dtrmc_pkg::HDR_FIRST + 8'd2);
        // zero step limit, controller number wraps past 127
        set_config(7'd127, 7'd0, 8'hFF);
        send_position(3'd6, 16'd5);

        run_random_phase(0, 0, 7'd0, 7'd63, 1'b1, 25);
        run_random_phase(47, 0, 7'd120, 7'h41, 1'b0, 25);
        run_random_phase(0, 47, 7'd127, 7'd32, 1'b0, 25);
        run_random_phase(25, 25, 7'd64, 7'd17, 1'b0, 25);

        wait_drained();
        repeat (140) @(negedge i_clk);

        $display("Sent %0d bytes; %0d runs (%0d clipped), %0d messages checked.",
                 bytes_sent, run_count, sat_runs, msg_count);
        $display("Register setups: reset, 127/0, 0/63, 120/65, 127/32, 64/17; long sink hold.");
        if (fail_count == 0 && pending == 0)
            $display("dial_to_relative_midi_cc: match");
        else
            $display("dial_to_relative_midi_cc: mismatch");
        $finish;
    end

endmodule
